FILE: hw/rtl/mte_pkg.sv
package mte_pkg;

  // field widths fixed by the stream format
  localparam int SampleW = 16;
  localparam int GainW   = 16;
  localparam int DelayW  = 16;
  localparam int NumW    = 5;
  localparam int FracW   = 14;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUM   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN  = 2'd2;

  // register reset values
  localparam logic [DelayW-1:0] DELAY_RST = 16'd0;
  localparam logic [NumW-1:0]   NUM_RST   = 5'd1;
  localparam logic [GainW-1:0]  GAIN_RST  = 16'd8192;

  // microprogram addresses
  localparam int StepW = 3;
  localparam logic [StepW-1:0] STEP_IDLE = 3'd0;
  localparam logic [StepW-1:0] STEP_RD   = 3'd1;
  localparam logic [StepW-1:0] STEP_MUL  = 3'd2;
  localparam logic [StepW-1:0] STEP_ACC  = 3'd3;
  localparam logic [StepW-1:0] STEP_OUT  = 3'd4;

  // jump conditions
  localparam logic [1:0] COND_NONE   = 2'd0;
  localparam logic [1:0] COND_NOTAP  = 2'd1;
  localparam logic [1:0] COND_MORE   = 2'd2;
  localparam logic [1:0] COND_ALWAYS = 2'd3;

  typedef struct packed {
    logic             wait_in;  // hold here until an input transfer
    logic             rd;       // read history at current tap index
    logic             mul;      // multiply stage, advance tap lag/index
    logic             acc;      // accumulate, update gain power
    logic             out_en;   // load output register
    logic [1:0]       cond;
    logic [StepW-1:0] jmp;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic no_taps;
    logic more;
  } seq_stat_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic rd;
    logic mul;
    logic acc;
    logic load_out;
  } seq_ctrl_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] addr);
    ucode_t w;
    w = '0;
    unique case (addr)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
        w.cond    = COND_NOTAP;
        w.jmp     = STEP_OUT;
      end
      STEP_RD: begin
        w.rd = 1'b1;
      end
      STEP_MUL: begin
        w.mul = 1'b1;
      end
      STEP_ACC: begin
        w.acc  = 1'b1;
        w.rd   = 1'b1;
        w.cond = COND_MORE;
        w.jmp  = STEP_MUL;
      end
      STEP_OUT: begin
        w.out_en = 1'b1;
        w.cond   = COND_ALWAYS;
        w.jmp    = STEP_IDLE;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.jmp  = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/mte_in_if.sv
interface mte_in_if;
  import mte_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               stream_start;

  modport source (output valid, output sample_in, output stream_start, input ready);
  modport sink (input valid, input sample_in, input stream_start, output ready);
endinterface

FILE: hw/rtl/mte_out_if.sv
interface mte_out_if;
  import mte_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

FILE: hw/rtl/multi_tap_echo_filter.sv
// Channel  | Dir | Payload                              | Handshake
// in_ch    | in  | sample_in[15:0] s, stream_start      | valid/ready
// out_ch   | out | sample_out[15:0] s                   | valid/ready
// cfg_*    | in  | cfg_idx[1:0], cfg_wdata[15:0]        | cfg_we, no wait
//
// The microprogram runs accept and read steps, a multiply and an accumulate
// step per tap, and an output step, on a single multiplier pair and the single
// history read port. Synchronous active-low reset clears the sequencer,
// counters, configuration registers and output valid flag; payload registers
// and the history memory are not cleared, only history entries written in the
// stream contribute. A new sample is taken while the previous result still
// waits in the output register; the output step stalls only while it is full.
module multi_tap_echo_filter #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int MAX_ECHOES    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mte_in_if.sink                      in_ch,
  mte_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [mte_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [15:0]                 cfg_wdata
);
  import mte_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int LW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = ((LW > DelayW) ? LW : DelayW) + 1;
  localparam int KW = $clog2(MAX_ECHOES + 1);
  localparam logic [SW-1:0] DEPTH_S = SW'(HISTORY_DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(HISTORY_DEPTH - 1);

  // configuration registers
  logic [DelayW-1:0] delay_r;
  logic [NumW-1:0]   num_r;
  logic [GainW-1:0]  gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
      num_r   <= NUM_RST;
      gain_r  <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DELAY: delay_r <= cfg_wdata[DelayW-1:0];
        CFG_NUM:   num_r   <= cfg_wdata[NumW-1:0];
        CFG_GAIN:  gain_r  <= cfg_wdata[GainW-1:0];
        default:   ;
      endcase
    end
  end

  // sequencer
  seq_stat_t stat;
  seq_ctrl_t ctrl;

  mte_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // datapath state
  logic [AW-1:0]        wr_ptr_r;
  logic [LW-1:0]        seen_r;
  logic [LW-1:0]        lag_r;
  logic [AW-1:0]        idx_r;
  logic [KW-1:0]        rem_r;
  logic                 hit_r;
  logic signed [15:0]   rd_data_r;
  logic signed [15:0]   acc_r;
  logic [GainW-1:0]     g_r;
  logic signed [32:0]   prod_r;
  logic [31:0]          gprod_r;
  logic                 out_valid_r;
  logic signed [15:0]   out_data_r;

  logic signed [15:0]   hist_mem [HISTORY_DEPTH];

  // effective tap count
  logic [KW-1:0] taps;
  assign taps = (int'(num_r) > MAX_ECHOES) ? KW'(MAX_ECHOES) : KW'(num_r);

  assign stat.in_valid = in_ch.valid;
  assign stat.out_free = !out_valid_r || out_ch.ready;
  assign stat.no_taps  = (taps == '0);
  assign stat.more     = (rem_r != KW'(1));

  // shared lag/index stepper: first tap at accept, next tap in the multiply step
  logic [LW-1:0] lag_base;
  logic [AW-1:0] idx_base;
  logic [SW-1:0] lag_sum;
  logic [LW-1:0] lag_step;
  logic [SW-1:0] idx_ext;
  logic [SW-1:0] dly_ext;
  logic [AW-1:0] idx_step;

  assign lag_base = ctrl.accept ? '0 : lag_r;
  assign idx_base = ctrl.accept ? wr_ptr_r : idx_r;
  assign dly_ext  = SW'(delay_r);
  assign lag_sum  = SW'(lag_base) + dly_ext;
  assign lag_step = (lag_sum >= DEPTH_S) ? DEPTH_L : LW'(lag_sum);
  assign idx_ext  = SW'(idx_base);
  assign idx_step = (idx_ext >= dly_ext) ? AW'(idx_ext - dly_ext)
                                         : AW'(idx_ext + DEPTH_S - dly_ext);

  // tap in range of both stream count and history
  logic hit;
  assign hit = (lag_r <= seen_r) && (lag_r < DEPTH_L);

  // history memory
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      hist_mem[wr_ptr_r] <= in_ch.sample_in;
    end
    if (ctrl.rd) begin
      rd_data_r <= hist_mem[idx_r];
    end
  end

  // tap accumulate: truncate toward zero, saturate
  logic signed [33:0] acc_sum;
  logic signed [19:0] acc_quo;
  logic signed [15:0] acc_sat;

  assign acc_sum = {{4{acc_r[15]}}, acc_r, 14'b0} + {prod_r[32], prod_r};

  always_comb begin
    acc_quo = acc_sum[33:14];
    if (acc_sum[33] && (acc_sum[13:0] != '0)) begin
      acc_quo = acc_quo + 20'sd1;
    end
    if (acc_quo > 20'sd32767) begin
      acc_sat = 16'sh7FFF;
    end else if (acc_quo < -20'sd32768) begin
      acc_sat = 16'sh8000;
    end else begin
      acc_sat = acc_quo[15:0];
    end
  end

  // next gain power, saturated
  logic [GainW-1:0] g_nxt;
  assign g_nxt = (gprod_r[31:30] != 2'b00) ? '1 : gprod_r[29:14];

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      acc_r <= in_ch.sample_in;
      g_r   <= gain_r;
      idx_r <= idx_step;
    end
    if (ctrl.rd) begin
      hit_r <= hit;
    end
    if (ctrl.mul) begin
      prod_r  <= hit_r ? ($signed({1'b0, g_r}) * rd_data_r) : 33'sd0;
      gprod_r <= g_r * gain_r;
      idx_r   <= idx_step;
    end
    if (ctrl.acc) begin
      acc_r <= acc_sat;
      g_r   <= g_nxt;
    end
    if (ctrl.load_out) begin
      out_data_r <= acc_r;
    end
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      seen_r      <= '0;
      lag_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
        if (in_ch.stream_start) begin
          seen_r <= '0;
        end
        lag_r <= lag_step;
        rem_r <= taps;
      end
      if (ctrl.mul) begin
        lag_r <= lag_step;
      end
      if (ctrl.acc) begin
        rem_r <= rem_r - KW'(1);
      end
      if (ctrl.load_out) begin
        if (seen_r < DEPTH_L) begin
          seen_r <= seen_r + LW'(1);
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready       = ctrl.in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

endmodule

FILE: hw/rtl/mte_seq.sv
module mte_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  mte_pkg::seq_stat_t  stat,
  output mte_pkg::seq_ctrl_t  ctrl
);
  import mte_pkg::*;

  logic [StepW-1:0] pc_r;
  logic [StepW-1:0] pc_nxt;
  ucode_t           word;
  logic             stall;
  logic             take;

  assign word = ucode_rom(pc_r);

  // hold on missing input or a full output register
  assign stall = (word.wait_in && !stat.in_valid) || (word.out_en && !stat.out_free);

  always_comb begin
    unique case (word.cond)
      COND_NONE:   take = 1'b0;
      COND_NOTAP:  take = stat.no_taps;
      COND_MORE:   take = stat.more;
      COND_ALWAYS: take = 1'b1;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = word.jmp;
    end else begin
      pc_nxt = pc_r + StepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // decoded strobes for the datapath
  assign ctrl.in_ready = word.wait_in;
  assign ctrl.accept   = word.wait_in && stat.in_valid;
  assign ctrl.rd       = word.rd;
  assign ctrl.mul      = word.mul;
  assign ctrl.acc      = word.acc;
  assign ctrl.load_out = word.out_en && stat.out_free;

endmodule
